@@ hw/rtl/assert_macros.svh @@
// assertion macros shared by the cuckoo filter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property check, disabled during reset
`define CFE_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also runs during reset
`define CFE_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/cfe_pkg.sv @@
// package: constants, types and helpers of the cuckoo filter engine
package cfe_pkg;

    localparam int MAX_BUCKETS = 4096;
    localparam int MAX_SLOTS   = 4;

    localparam int HASH_W      = 64;
    localparam int FP_W        = 16;
    localparam int BUCKET_W    = $clog2(MAX_BUCKETS);
    localparam int BCOUNT_W    = 13;
    localparam int SLOTS_W     = 3;
    localparam int KICKS_W     = 12;
    localparam int LFSR_W      = 32;
    localparam int TOTAL_W     = 15;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SLOT_IDX_W  = $clog2(MAX_SLOTS);
    localparam int FILL_W      = 3;
    localparam int PROD_W      = FP_W + 32;
    localparam int MOD_CNT_W   = $clog2(HASH_W);

    localparam logic [31:0]         ALT_MULT  = 32'h5bd1e995;
    localparam logic [LFSR_W-1:0]   LFSR_TAPS = 32'h80200003;
    localparam logic [TOTAL_W-1:0]  TOTAL_MAX = 15'h7fff;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BUCKET_COUNT = 2'd0,
        CFG_BUCKET_SLOTS = 2'd1,
        CFG_MAX_KICKS    = 2'd2,
        CFG_RANDOM_SEED  = 2'd3
    } cfg_idx_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_HOME_WAIT,
        S_ALT_MUL,
        S_ALT_START,
        S_ALT_WAIT,
        S_LK_RDF,
        S_LK_GETF,
        S_LK_SCAN,
        S_LK_CMP,
        S_PF_RD,
        S_PF_CHK,
        S_KICK,
        S_VIC_WAIT,
        S_SWAP,
        S_K_MUL,
        S_K_START,
        S_K_WAIT,
        S_DONE
    } state_t;

    // request to the shared modulo unit
    typedef struct packed {
        logic                start;
        logic [HASH_W-1:0]   dividend;
        logic [BCOUNT_W-1:0] divisor;
    } mod_req_t;

    // answer of the shared modulo unit
    typedef struct packed {
        logic                done;
        logic [BCOUNT_W-1:0] rem;
    } mod_rsp_t;

    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        return n;
    endfunction

endpackage

@@ hw/rtl/cfe_if.sv @@
// request and response channel interfaces
interface cfe_req_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [cfe_pkg::HASH_W-1:0] key_hash;

    modport source (output valid, output mode, output key_hash, input ready);
    modport sink   (input valid, input mode, input key_hash, output ready);
endinterface

interface cfe_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       ok;
    logic [cfe_pkg::TOTAL_W-1:0] stored_count;

    modport source (output valid, output ok, output stored_count, input ready);
    modport sink   (input valid, input ok, input stored_count, output ready);
endinterface

@@ hw/rtl/cfe_mod.sv @@
// shared restoring modulo unit, one dividend bit per cycle
module cfe_mod (
    input  logic              clk,
    input  logic              rst_n,
    input  cfe_pkg::mod_req_t req,
    output cfe_pkg::mod_rsp_t rsp
);
    import cfe_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [HASH_W-1:0]    dvd_reg;
    logic [BCOUNT_W-1:0]  dvs_reg;
    logic [BCOUNT_W-1:0]  rem_reg;
    logic [BCOUNT_W:0]    trial;
    logic [BCOUNT_W-1:0]  rem_next;

    always_comb
    begin
        trial = {rem_reg, dvd_reg[HASH_W-1]};
        if (trial >= {1'b0, dvs_reg})
        begin
            rem_next = BCOUNT_W'(trial - {1'b0, dvs_reg});
        end
        else
        begin
            rem_next = trial[BCOUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == MOD_CNT_W'(HASH_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_next;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.rem  = rem_reg;

endmodule

@@ hw/rtl/cuckoo_filter_engine.sv @@
// top level of the cuckoo filter engine: sequencer, tables and result register
// usage:
//  - req channel (valid/ready) carries one request: mode (0 insert, 1 lookup)
//    and a 64-bit precomputed key hash; fingerprint is hash[15:0]
//  - rsp channel (valid/ready) returns one result per request: ok and the
//    saturating count of stored fingerprints after the request
//  - cfg_we/cfg_index/cfg_data write bucket_count, bucket_slots, max_kicks
//    and random_seed; a seed write reloads the victim lfsr at once
//  - one request at a time; every bucket index comes out of a shared
//    restoring modulo unit
//  - lookup: 2 modulo passes plus bucket scans
//  - insert: lookup plus up to max_kicks eviction steps per candidate bucket
//  - after reset a clearing pass zeroes the bucket fill counts; req.ready
//    stays low meanwhile, config writes are still taken
//  - the result sits in an output register, so a new request is taken
//    while the previous result waits for rsp.ready; a result that finds
//    the register still full waits there until the receiver takes it
`include "assert_macros.svh"

module cuckoo_filter_engine (
    input  logic                             clk,
    input  logic                             rst_n,
    cfe_req_if.sink                          req,
    cfe_rsp_if.source                        rsp,
    input  logic                             cfg_we,
    input  logic [cfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cfe_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import cfe_pkg::*;

    localparam int SLOT_AW = BUCKET_W + SLOT_IDX_W;

    // configuration
    logic [BCOUNT_W-1:0] bcount_reg;
    logic [SLOTS_W-1:0]  bslots_reg;
    logic [KICKS_W-1:0]  kicks_reg;
    logic [LFSR_W-1:0]   lfsr_reg;
    logic [BCOUNT_W-1:0] eff_buckets;
    logic [SLOTS_W-1:0]  eff_slots;

    // sequencer
    state_t state_reg;
    state_t state_next;

    // working registers
    logic                mode_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [BUCKET_W-1:0] b1_reg;
    logic [BUCKET_W-1:0] b2_reg;
    logic [BUCKET_W-1:0] cur_b_reg;
    logic [FP_W-1:0]     cur_f_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   k_reg;
    logic [SLOT_IDX_W-1:0] vic_reg;
    logic [KICKS_W-1:0]  kick_reg;
    logic                lk_sec_reg;
    logic                cand_reg;
    logic                chain_reg;
    logic                ok_reg;
    logic [TOTAL_W-1:0]  total_reg;
    logic [BUCKET_W-1:0] clr_reg;

    // result register
    logic                out_valid_reg;
    logic                out_ok_reg;
    logic [TOTAL_W-1:0]  out_count_reg;

    // tables
    logic [FP_W-1:0]     slot_mem [MAX_BUCKETS*MAX_SLOTS];
    logic [FILL_W-1:0]   fill_mem [MAX_BUCKETS];
    logic [FP_W-1:0]     slot_q;
    logic [FILL_W-1:0]   fill_q;

    // memory and unit controls
    logic                fill_we;
    logic [BUCKET_W-1:0] fill_waddr;
    logic [FILL_W-1:0]   fill_wdata;
    logic [BUCKET_W-1:0] fill_raddr;
    logic                slot_we;
    logic [SLOT_AW-1:0]  slot_waddr;
    logic [FP_W-1:0]     slot_wdata;
    logic [SLOT_AW-1:0]  slot_raddr;
    mod_req_t            mod_req;
    mod_rsp_t            mod_rsp;
    logic                req_fire;
    logic                out_load;
    logic                fits;
    logic                kick_over;
    logic [LFSR_W-1:0]   lfsr_nxt;
    logic                scan_more;
    logic                hit;
    logic                mod_wait;

    // out-of-range settings clamp to the nearest legal value
    always_comb
    begin
        if (bcount_reg == '0)
        begin
            eff_buckets = BCOUNT_W'(1);
        end
        else if (bcount_reg > BCOUNT_W'(MAX_BUCKETS))
        begin
            eff_buckets = BCOUNT_W'(MAX_BUCKETS);
        end
        else
        begin
            eff_buckets = bcount_reg;
        end

        if (bslots_reg == '0)
        begin
            eff_slots = SLOTS_W'(1);
        end
        else if (bslots_reg > SLOTS_W'(MAX_SLOTS))
        begin
            eff_slots = SLOTS_W'(MAX_SLOTS);
        end
        else
        begin
            eff_slots = bslots_reg;
        end
    end

    assign req_fire  = req.valid && req.ready;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || rsp.ready);
    assign fits      = (fill_q < eff_slots);
    assign kick_over = (kick_reg >= kicks_reg) || (fill_reg == '0);
    assign lfsr_nxt  = lfsr_step(lfsr_reg);
    assign scan_more = (k_reg < fill_reg);
    assign hit       = (slot_q == hash_reg[FP_W-1:0]);
    assign mod_wait  = (state_reg inside {S_HOME_WAIT, S_ALT_WAIT, S_VIC_WAIT, S_K_WAIT});

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.ok           = out_ok_reg;
    assign rsp.stored_count = out_count_reg;

    cfe_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .rsp   (mod_rsp)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = S_HOME_WAIT;
                end
            end
            S_HOME_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_ALT_MUL;
                end
            end
            S_ALT_MUL:   state_next = S_ALT_START;
            S_ALT_START: state_next = S_ALT_WAIT;
            S_ALT_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_LK_RDF;
                end
            end
            S_LK_RDF:  state_next = S_LK_GETF;
            S_LK_GETF: state_next = S_LK_SCAN;
            S_LK_SCAN:
            begin
                if (scan_more)
                begin
                    state_next = S_LK_CMP;
                end
                else if (!lk_sec_reg)
                begin
                    state_next = S_LK_RDF;
                end
                else if (mode_reg == MODE_LOOKUP)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_PF_RD;
                end
            end
            S_LK_CMP:
            begin
                state_next = hit ? S_DONE : S_LK_SCAN;
            end
            S_PF_RD: state_next = S_PF_CHK;
            S_PF_CHK:
            begin
                state_next = fits ? S_DONE : S_KICK;
            end
            S_KICK:
            begin
                if (!kick_over)
                begin
                    state_next = S_VIC_WAIT;
                end
                else if (!cand_reg)
                begin
                    state_next = S_PF_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_VIC_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_SWAP;
                end
            end
            S_SWAP:    state_next = S_K_MUL;
            S_K_MUL:   state_next = S_K_START;
            S_K_START: state_next = S_K_WAIT;
            S_K_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    state_next = S_PF_RD;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // memory ports and modulo unit requests
    always_comb
    begin
        fill_we          = 1'b0;
        fill_waddr       = cur_b_reg;
        fill_wdata       = FILL_W'(fill_q + 1'b1);
        fill_raddr       = cur_b_reg;
        slot_we          = 1'b0;
        slot_waddr       = {cur_b_reg, fill_q[SLOT_IDX_W-1:0]};
        slot_wdata       = cur_f_reg;
        slot_raddr       = {cur_b_reg, k_reg[SLOT_IDX_W-1:0]};
        mod_req.start    = 1'b0;
        mod_req.dividend = req.key_hash;
        mod_req.divisor  = eff_buckets;
        case (state_reg)
            S_CLEAR:
            begin
                fill_we    = 1'b1;
                fill_waddr = clr_reg;
                fill_wdata = '0;
            end
            S_IDLE:
            begin
                mod_req.start = req_fire;
            end
            S_ALT_START:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = HASH_W'(prod_reg ^ PROD_W'(b1_reg));
            end
            S_PF_CHK:
            begin
                fill_we = fits;
                slot_we = fits;
            end
            S_KICK:
            begin
                mod_req.start    = !kick_over;
                mod_req.dividend = HASH_W'(lfsr_nxt);
                mod_req.divisor  = BCOUNT_W'(fill_reg);
            end
            S_VIC_WAIT:
            begin
                slot_raddr = {cur_b_reg, mod_rsp.rem[SLOT_IDX_W-1:0]};
            end
            S_SWAP:
            begin
                slot_we    = 1'b1;
                slot_waddr = {cur_b_reg, vic_reg};
            end
            S_K_START:
            begin
                mod_req.start    = 1'b1;
                mod_req.dividend = HASH_W'(prod_reg ^ PROD_W'(cur_b_reg));
            end
            default:
            begin
            end
        endcase
    end

    // sequencer state and clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // configuration registers and victim lfsr
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bcount_reg <= BCOUNT_W'(MAX_BUCKETS);
            bslots_reg <= SLOTS_W'(MAX_SLOTS);
            kicks_reg  <= KICKS_W'(2000);
            lfsr_reg   <= LFSR_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_BUCKET_COUNT: bcount_reg <= cfg_data[BCOUNT_W-1:0];
                CFG_BUCKET_SLOTS: bslots_reg <= cfg_data[SLOTS_W-1:0];
                CFG_MAX_KICKS:    kicks_reg  <= cfg_data[KICKS_W-1:0];
                CFG_RANDOM_SEED:
                begin
                    // a zero seed would lock the lfsr
                    lfsr_reg <= (cfg_data == '0) ? LFSR_W'(1) : cfg_data;
                end
                default:
                begin
                end
            endcase
        end
        else if ((state_reg == S_KICK) && !kick_over)
        begin
            lfsr_reg <= lfsr_nxt;
        end
    end

    // stored fingerprint counter and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // a new fingerprint got a place
            if ((state_reg == S_PF_CHK) && fits && (total_reg < TOTAL_MAX))
            begin
                total_reg <= total_reg + 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_ok_reg    <= ok_reg;
            out_count_reg <= total_reg;
        end
    end

    // datapath of the walk
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    mode_reg <= req.mode;
                    hash_reg <= req.key_hash;
                    ok_reg   <= 1'b0;
                end
            end
            S_HOME_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    b1_reg <= mod_rsp.rem[BUCKET_W-1:0];
                end
            end
            S_ALT_MUL:
            begin
                prod_reg <= PROD_W'(hash_reg[FP_W-1:0] * ALT_MULT);
            end
            S_ALT_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    b2_reg     <= mod_rsp.rem[BUCKET_W-1:0];
                    cur_b_reg  <= b1_reg;
                    lk_sec_reg <= 1'b0;
                end
            end
            S_LK_GETF:
            begin
                fill_reg <= fill_q;
                k_reg    <= '0;
            end
            S_LK_SCAN:
            begin
                if (!scan_more)
                begin
                    if (!lk_sec_reg)
                    begin
                        lk_sec_reg <= 1'b1;
                        cur_b_reg  <= b2_reg;
                    end
                    else
                    begin
                        // lookup missed both buckets, inserts start at home
                        cand_reg  <= 1'b0;
                        chain_reg <= 1'b0;
                        cur_b_reg <= b1_reg;
                        cur_f_reg <= hash_reg[FP_W-1:0];
                    end
                end
            end
            S_LK_CMP:
            begin
                if (hit)
                begin
                    ok_reg <= 1'b1;
                end
                k_reg <= k_reg + 1'b1;
            end
            S_PF_CHK:
            begin
                fill_reg <= fill_q;
                if (fits)
                begin
                    ok_reg <= 1'b1;
                end
                else
                begin
                    kick_reg  <= chain_reg ? kick_reg + 1'b1 : '0;
                    chain_reg <= 1'b1;
                end
            end
            S_KICK:
            begin
                if (kick_over && !cand_reg)
                begin
                    // chain gave up: retry from the alternate bucket
                    cand_reg  <= 1'b1;
                    chain_reg <= 1'b0;
                    cur_b_reg <= b2_reg;
                    cur_f_reg <= hash_reg[FP_W-1:0];
                end
            end
            S_VIC_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    vic_reg <= mod_rsp.rem[SLOT_IDX_W-1:0];
                end
            end
            S_SWAP:
            begin
                cur_f_reg <= slot_q;
            end
            S_K_MUL:
            begin
                prod_reg <= PROD_W'(cur_f_reg * ALT_MULT);
            end
            S_K_WAIT:
            begin
                if (mod_rsp.done)
                begin
                    cur_b_reg <= mod_rsp.rem[BUCKET_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    // tables, read data registered
    always_ff @(posedge clk)
    begin
        if (fill_we)
        begin
            fill_mem[fill_waddr] <= fill_wdata;
        end
        fill_q <= fill_mem[fill_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_q <= slot_mem[slot_raddr];
    end

    `CFE_ASSERT(a_fill_bound, fill_we |-> (fill_wdata <= FILL_W'(MAX_SLOTS)), "fill above limit")
    `CFE_ASSERT(a_mod_done_waited, mod_rsp.done |-> mod_wait, "modulo result with no waiter")
    `CFE_ASSERT(a_kick_limit, (state_reg == S_KICK) |-> (kick_reg <= kicks_reg), "chain past limit")

endmodule
